// ----- rtl/bss_pkg.sv -----
// Shared types and constants for the backend server selector.
// Request/response item structs, command and mode codes, controller interface structs.
// No dependencies.
`timescale 1ns / 1ps

package bss_pkg;

  localparam int ENTRY_CAP       = 16;  // entries reachable by the 4-bit write index
  localparam int MAX_SERVERS_DEF = 16;
  localparam int LC_SHIFT        = 8;   // least-connections scale of 256
  localparam int DIV_W           = 32;
  localparam int DIVR_W          = 12;
  localparam int SCORE_W         = 24;

  localparam logic [1:0] CMD_WRITE    = 2'd0;
  localparam logic [1:0] CMD_URI      = 2'd1;
  localparam logic [1:0] CMD_DISPATCH = 2'd2;
  localparam logic [1:0] CMD_NOP      = 2'd3;  // ignored, no result

  localparam logic [2:0] MODE_RR   = 3'd0;
  localparam logic [2:0] MODE_SRR  = 3'd1;
  localparam logic [2:0] MODE_LC   = 3'd2;
  localparam logic [2:0] MODE_SRC  = 3'd3;
  localparam logic [2:0] MODE_URI  = 3'd4;
  localparam logic [2:0] MODE_RAND = 3'd5;
  localparam logic [2:0] MODE_RSV6 = 3'd6;  // behaves as round-robin
  localparam logic [2:0] MODE_RSV7 = 3'd7;  // behaves as round-robin

  localparam logic REG_LB_MODE = 1'b0;  // register index taken from paddr[2]

  typedef enum logic [1:0] {
    PICK_RR,
    PICK_KEY,
    PICK_HASH,
    PICK_LC
  } pick_t;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [3:0]  server_index;
    logic        usable;
    logic [11:0] weight;
    logic [15:0] conn_count;
    logic [7:0]  uri_byte;
    logic [31:0] key;
    logic        key_valid;
  } req_t;

  typedef struct packed {
    logic       found;
    logic [3:0] chosen_server;
  } rsp_t;

  typedef struct packed {
    logic  wr_entry;
    logic  uri_add;
    logic  disp_start;
    pick_t pick;
    logic  cnt_load;
    logic  mod_start;
    logic  tgt_load;
    logic  walk_step;
    logic  take;
    logic  lc_start;
    logic  lc_cmp_conn;
    logic  lc_cmp_quot;
    logic  finish;
  } ctl_t;

  typedef struct packed {
    logic uri_seen;
    logic n_zero;
    logic div_done;
    logic cur_usable;
    logic cur_wzero;
    logic hit;
    logic last;
    logic out_full;
  } sts_t;

endpackage

// ----- rtl/backend_server_selector_unit.sv -----
// Backend server selector, top level: APB mode register, controller and datapath.
// Uses bss_pkg, bss_ctrl, bss_datapath.
`timescale 1ns / 1ps

// Write-entry and URI-byte items are taken without a stall. A dispatch item walks the
// server table under a sequencer and holds req_stall until its result is loaded:
// round-robin, source, URI and random run the modulo divide and then walk the
// entries up to the pick; least-connections runs the shared divider once per usable
// weighted entry. With no usable server no divide runs and a not-found result
// is loaded. The result register lets the next item in while a result waits on
// rsp_stall. lb_mode sits at byte address 0.

module backend_server_selector_unit
  import bss_pkg::*;
#(
  parameter int MAX_SERVERS = MAX_SERVERS_DEF
)(
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        req_valid,
  output logic        req_stall,
  input  req_t        req,
  output logic        rsp_valid,
  input  logic        rsp_stall,
  output rsp_t        rsp
);

  logic [2:0] lb_mode;
  ctl_t       ctl;
  sts_t       sts;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_LB_MODE) ? {29'd0, lb_mode} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      lb_mode <= MODE_RR;
    end else if (psel && penable && pwrite && pready && paddr[2] == REG_LB_MODE) begin
      lb_mode <= pwdata[2:0];
    end
  end

  bss_ctrl u_ctrl (
    .clk           (clk),
    .rst           (rst),
    .lb_mode       (lb_mode),
    .req_valid     (req_valid),
    .req_stall     (req_stall),
    .req_cmd       (req.cmd),
    .req_key_valid (req.key_valid),
    .sts           (sts),
    .ctl           (ctl)
  );

  bss_datapath #(
    .MAX_SERVERS (MAX_SERVERS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .ctl       (ctl),
    .sts       (sts),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

endmodule

// ----- rtl/bss_div.sv -----
// Radix-2 restoring divider, one quotient bit per cycle.
// Used for the selection modulo and the least-connections score. Uses bss_pkg.
`timescale 1ns / 1ps

module bss_div
  import bss_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [DIV_W-1:0]  dividend,
  input  logic [DIVR_W-1:0] divisor,
  output logic              done,
  output logic [DIV_W-1:0]  quot,
  output logic [DIVR_W-1:0] rem
);

  localparam int CW = $clog2(DIV_W);

  logic                      busy;
  logic [CW-1:0]             cnt;
  logic [DIVR_W-1:0]         d;
  logic [DIVR_W:0]           r2;

  assign r2 = {rem, quot[DIV_W-1]};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == CW'(DIV_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quot <= dividend;
      rem  <= '0;
      d    <= divisor;
    end else if (busy) begin
      if (r2 >= {1'b0, d}) begin
        rem  <= DIVR_W'(r2 - {1'b0, d});
        quot <= {quot[DIV_W-2:0], 1'b1};
      end else begin
        rem  <= r2[DIVR_W-1:0];
        quot <= {quot[DIV_W-2:0], 1'b0};
      end
    end
  end

endmodule

// ----- rtl/bss_datapath.sv -----
// Server table, hash, round-robin counter, selection walk and result register.
// Driven by bss_ctrl through ctl_t/sts_t; instantiates bss_div. Uses bss_pkg.
`timescale 1ns / 1ps

module bss_datapath
  import bss_pkg::*;
#(
  parameter int MAX_SERVERS = MAX_SERVERS_DEF
)(
  input  logic clk,
  input  logic rst,
  input  req_t req,
  input  ctl_t ctl,
  output sts_t sts,
  output logic rsp_valid,
  input  logic rsp_stall,
  output rsp_t rsp
);

  localparam int NUM_ENT = (MAX_SERVERS < ENTRY_CAP) ? MAX_SERVERS : ENTRY_CAP;
  localparam int IW      = $clog2(NUM_ENT);

  logic [NUM_ENT-1:0] usable_bits;
  logic [11:0]        weights [NUM_ENT];
  logic [15:0]        conns   [NUM_ENT];
  logic [31:0]        rr_counter;
  logic [31:0]        uri_hash;
  logic               uri_seen;

  logic [31:0]        sel;
  logic [IW:0]        n;
  logic [IW-1:0]      walk_idx;
  logic [IW-1:0]      k;
  logic [IW-1:0]      target;
  logic               found;
  logic [IW-1:0]      chosen;
  logic [SCORE_W-1:0] best;

  logic               div_start;
  logic [DIV_W-1:0]   div_dividend;
  logic [DIVR_W-1:0]  div_divisor;
  logic               div_done;
  logic [DIV_W-1:0]   div_quot;
  logic [DIVR_W-1:0]  div_rem;
  logic [SCORE_W-1:0] score;
  logic               wr_ok;

  assign wr_ok = {1'b0, req.server_index} < 5'(NUM_ENT);

  assign div_start    = ctl.mod_start | ctl.lc_start;
  assign div_dividend = ctl.lc_start ? {8'd0, conns[walk_idx], 8'd0} : sel;
  assign div_divisor  = ctl.lc_start ? weights[walk_idx] : DIVR_W'(n);

  bss_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quot     (div_quot),
    .rem      (div_rem)
  );

  assign score = ctl.lc_cmp_quot ? div_quot[SCORE_W-1:0] : SCORE_W'(conns[walk_idx]);

  assign sts.uri_seen   = uri_seen;
  assign sts.n_zero     = (n == '0);
  assign sts.div_done   = div_done;
  assign sts.cur_usable = usable_bits[walk_idx];
  assign sts.cur_wzero  = (weights[walk_idx] == '0);
  assign sts.hit        = usable_bits[walk_idx] && (k == target);
  assign sts.last       = (walk_idx == IW'(NUM_ENT - 1));
  assign sts.out_full   = rsp_valid && rsp_stall;

  // Table, hash and round-robin state
  always_ff @(posedge clk) begin
    if (rst) begin
      usable_bits <= '0;
      for (int j = 0; j < NUM_ENT; j++) begin
        weights[j] <= '0;
        conns[j]   <= '0;
      end
      rr_counter <= '0;
      uri_hash   <= '0;
      uri_seen   <= 1'b0;
    end else begin
      if (ctl.wr_entry && wr_ok) begin
        usable_bits[req.server_index[IW-1:0]] <= req.usable;
        weights[req.server_index[IW-1:0]]     <= req.weight;
        conns[req.server_index[IW-1:0]]       <= req.conn_count;
      end
      if (ctl.uri_add) begin
        uri_hash <= (uri_hash << 5) + uri_hash + {24'd0, req.uri_byte};
        uri_seen <= 1'b1;
      end
      if (ctl.disp_start && ctl.pick == PICK_RR) begin
        rr_counter <= rr_counter + 1'b1;
      end
      if (ctl.finish) begin
        if (found && conns[chosen] != 16'hFFFF) begin
          conns[chosen] <= conns[chosen] + 1'b1;
        end
        uri_hash <= '0;
        uri_seen <= 1'b0;
      end
    end
  end

  // Selection working registers
  always_ff @(posedge clk) begin
    if (ctl.disp_start) begin
      case (ctl.pick)
        PICK_RR:   sel <= rr_counter;
        PICK_KEY:  sel <= req.key;
        PICK_HASH: sel <= uri_hash;
        default:   sel <= '0;
      endcase
    end
    if (ctl.cnt_load) begin
      n        <= (IW + 1)'($countones(usable_bits));
      walk_idx <= '0;
      k        <= '0;
      found    <= 1'b0;
      chosen   <= '0;
    end
    if (ctl.tgt_load) begin
      target <= div_rem[IW-1:0];
    end
    if (ctl.take) begin
      found  <= 1'b1;
      chosen <= walk_idx;
    end
    // first strict minimum wins
    if (ctl.lc_cmp_conn || ctl.lc_cmp_quot) begin
      if (!found || score < best) begin
        found  <= 1'b1;
        best   <= score;
        chosen <= walk_idx;
      end
    end
    if (ctl.walk_step) begin
      walk_idx <= walk_idx + 1'b1;
      if (usable_bits[walk_idx]) begin
        k <= k + 1'b1;
      end
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (ctl.finish) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.finish) begin
      rsp.found         <= found;
      rsp.chosen_server <= 4'(chosen);
    end
  end

`ifndef ASSERT_OFF
  a_take_usable: assert property (@(posedge clk) disable iff (rst)
    ctl.take |-> usable_bits[walk_idx])
    else $error("picked entry is not usable");

  a_target_range: assert property (@(posedge clk) disable iff (rst)
    ctl.tgt_load |-> (div_rem < DIVR_W'(n)))
    else $error("selection remainder out of range");

  a_finish_clears: assert property (@(posedge clk) disable iff (rst)
    ctl.finish |=> rsp_valid && !uri_seen && uri_hash == '0)
    else $error("dispatch end did not post result or clear hash");
`endif

endmodule

// ----- rtl/bss_ctrl.sv -----
// Dispatch sequencer for the backend server selector.
// Drives bss_datapath via ctl_t and reads sts_t. Uses bss_pkg.
`timescale 1ns / 1ps

module bss_ctrl
  import bss_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic [2:0] lb_mode,
  input  logic       req_valid,
  output logic       req_stall,
  input  logic [1:0] req_cmd,
  input  logic       req_key_valid,
  input  sts_t       sts,
  output ctl_t       ctl
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_COUNT,
    S_MODDIV,
    S_MODWAIT,
    S_NTH,
    S_LCENT,
    S_LCWAIT,
    S_FINISH
  } state_t;

  state_t state, state_next;
  pick_t  pick_q, pick_sel;
  logic   acc;

  assign req_stall = (state != S_IDLE);
  assign acc       = req_valid && !req_stall;

  always_comb begin
    case (lb_mode)
      MODE_LC:   pick_sel = PICK_LC;
      MODE_SRC:  pick_sel = req_key_valid ? PICK_KEY : PICK_RR;
      MODE_URI:  pick_sel = sts.uri_seen ? PICK_HASH : PICK_RR;
      MODE_RAND: pick_sel = PICK_KEY;
      default:   pick_sel = PICK_RR;
    endcase
  end

  always_comb begin
    ctl        = '0;
    ctl.pick   = pick_sel;
    state_next = state;
    case (state)
      S_IDLE: begin
        if (acc) begin
          ctl.wr_entry   = (req_cmd == CMD_WRITE);
          ctl.uri_add    = (req_cmd == CMD_URI);
          ctl.disp_start = (req_cmd == CMD_DISPATCH);
          if (req_cmd == CMD_DISPATCH) state_next = S_COUNT;
        end
      end
      S_COUNT: begin
        ctl.cnt_load = 1'b1;
        state_next   = (pick_q == PICK_LC) ? S_LCENT : S_MODDIV;
      end
      S_MODDIV: begin
        if (sts.n_zero) begin
          state_next = S_FINISH;
        end else begin
          ctl.mod_start = 1'b1;
          state_next    = S_MODWAIT;
        end
      end
      S_MODWAIT: begin
        if (sts.div_done) begin
          ctl.tgt_load = 1'b1;
          state_next   = S_NTH;
        end
      end
      S_NTH: begin
        if (sts.hit) begin
          ctl.take   = 1'b1;
          state_next = S_FINISH;
        end else begin
          ctl.walk_step = 1'b1;
        end
      end
      S_LCENT: begin
        if (sts.n_zero) begin
          state_next = S_FINISH;
        end else if (sts.cur_usable && !sts.cur_wzero) begin
          ctl.lc_start = 1'b1;
          state_next   = S_LCWAIT;
        end else begin
          ctl.lc_cmp_conn = sts.cur_usable;
          if (sts.last) state_next = S_FINISH;
          else ctl.walk_step = 1'b1;
        end
      end
      S_LCWAIT: begin
        if (sts.div_done) begin
          ctl.lc_cmp_quot = 1'b1;
          if (sts.last) begin
            state_next = S_FINISH;
          end else begin
            ctl.walk_step = 1'b1;
            state_next    = S_LCENT;
          end
        end
      end
      S_FINISH: begin
        if (!sts.out_full) begin
          ctl.finish = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      pick_q <= PICK_RR;
    end else begin
      state <= state_next;
      if (ctl.disp_start) pick_q <= pick_sel;
    end
  end

`ifndef ASSERT_OFF
  a_disp_seq: assert property (@(posedge clk) disable iff (rst)
    ctl.disp_start |=> state == S_COUNT)
    else $error("dispatch item did not start selection");

  a_finish_idle: assert property (@(posedge clk) disable iff (rst)
    ctl.finish |=> state == S_IDLE && !req_stall)
    else $error("controller did not return to idle after result");

  a_div_one: assert property (@(posedge clk) disable iff (rst)
    (ctl.mod_start || ctl.lc_start) |=> (state == S_MODWAIT || state == S_LCWAIT))
    else $error("divider started outside a wait sequence");
`endif

endmodule
